@@ rtl/rqac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rqac_pkg;

   // Size of the external memory that holds the queue region, in bytes.
   parameter logic [32:0] MEM_BYTES = 33'd8388608;

   parameter int unsigned ADDR_W   = 23;
   parameter int unsigned COUNT_W  = 24;
   parameter int unsigned ENTRY_W  = 16;
   parameter int unsigned STATUS_W = 3;
   parameter int unsigned OP_W     = 2;
   parameter int unsigned CSR_IDX_W = 2;
   parameter int unsigned CSR_DATA_W = 24;
   parameter int unsigned ALU_W    = 24;

   // Restoring divide: one quotient bit per step. Shift-add multiply: one
   // multiplier bit per step.
   parameter int unsigned DIV_STEPS = 24;
   parameter int unsigned MUL_STEPS = 16;
   parameter int unsigned STEP_W    = 5;

   parameter logic [ADDR_W-1:0]  RESET_BASE   = 23'd0;
   parameter logic [COUNT_W-1:0] RESET_REGION = 24'd8388608;
   parameter logic [ENTRY_W-1:0] RESET_ENTRY  = 16'd1;

   parameter logic RESET_OK = (RESET_ENTRY != 16'd0)
      && (RESET_REGION >= COUNT_W'(RESET_ENTRY))
      && ((33'(RESET_BASE) + 33'(RESET_REGION)) <= MEM_BYTES);

   parameter logic [COUNT_W-1:0] RESET_CAP =
      RESET_OK ? COUNT_W'(RESET_REGION / RESET_ENTRY) : '0;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_GET   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_INVALID = 3'd3,
      ST_FAULT   = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BASE  = 2'd0,
      CSR_REGION_BYTES = 2'd1,
      CSR_ENTRY_BYTES  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_MUL,
      S_FINISH
   } state_type;

   // Strobes from the sequencer to the datapath.
   typedef struct packed {
      logic accept;
      logic check;
      logic div_step;
      logic div_last;
      logic mul_step;
      logic finish;
   } ctrl_type;

endpackage

`default_nettype wire

@@ rtl/rqac_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

// The adder shared by the multiply and divide. Subtract mode adds the complement plus one;
// the carry out then means no borrow.
module rqac_alu (
   input  wire logic [rqac_pkg::ALU_W-1:0] op_a,
   input  wire logic [rqac_pkg::ALU_W-1:0] op_b,
   input  wire logic                       subtract,
   output logic      [rqac_pkg::ALU_W:0]   sum
);

   logic [rqac_pkg::ALU_W-1:0] b_eff;

   always_comb begin
      b_eff = subtract ? ~op_b : op_b;
      sum   = {1'b0, op_a} + {1'b0, b_eff} + {{rqac_pkg::ALU_W{1'b0}}, subtract};
   end

endmodule

`default_nettype wire

@@ rtl/rqac_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rqac_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              cfg_write,
   input  wire logic              xfer_now,
   input  wire logic              check_ok,
   output logic                   busy,
   output rqac_pkg::ctrl_type     ctrl
);

   rqac_pkg::state_type          state_ff, state_in;
   logic [rqac_pkg::STEP_W-1:0]  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rqac_pkg::S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ctrl     = '0;
      busy     = (state_ff != rqac_pkg::S_IDLE);
      case (state_ff)
         rqac_pkg::S_IDLE: begin
            if (start) begin
               ctrl.accept = 1'b1;
               step_in     = '0;
               state_in    = xfer_now ? rqac_pkg::S_MUL : rqac_pkg::S_FINISH;
            end
         end
         rqac_pkg::S_CHECK: begin
            ctrl.check = 1'b1;
            step_in    = '0;
            state_in   = check_ok ? rqac_pkg::S_DIV : rqac_pkg::S_IDLE;
         end
         rqac_pkg::S_DIV: begin
            ctrl.div_step = 1'b1;
            step_in       = step_ff + rqac_pkg::STEP_W'(1);
            if (step_ff == rqac_pkg::STEP_W'(rqac_pkg::DIV_STEPS - 1)) begin
               ctrl.div_last = 1'b1;
               state_in      = rqac_pkg::S_IDLE;
            end
         end
         rqac_pkg::S_MUL: begin
            ctrl.mul_step = 1'b1;
            step_in       = step_ff + rqac_pkg::STEP_W'(1);
            if (step_ff == rqac_pkg::STEP_W'(rqac_pkg::MUL_STEPS - 1)) begin
               state_in = rqac_pkg::S_FINISH;
            end
         end
         rqac_pkg::S_FINISH: begin
            ctrl.finish = 1'b1;
            state_in    = rqac_pkg::S_IDLE;
         end
         default: begin
            state_in = rqac_pkg::S_IDLE;
         end
      endcase
      // A register write restarts validation and the capacity divide.
      if (cfg_write) begin
         state_in = rqac_pkg::S_CHECK;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ring_queue_address_controller_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Address and bookkeeping controller for a ring queue of fixed-size items in
// an external memory region. A command beat is taken when start is high and
// busy is low; exactly one result beat follows, shown for one cycle with
// rsp_valid high, and the receiver cannot stall it, so it must capture the
// result in that cycle. A put, get or peek that issues a transfer passes
// from acceptance through a shift-add multiply over the 16 bits of the item
// size, which forms base plus index times item size, and then the pointer
// update; a command that issues no transfer (clear, refused, invalid
// configuration) goes from acceptance straight to the pointer update. Busy
// falls in the cycle the result is shown, so the next command can be taken
// then. Every write to one of the three configuration registers clears the
// pointers and count and then keeps busy high for a validation step plus, for a
// valid region, a restoring division of the 24 region bits into the capacity
// in items; writes to an undefined index are ignored. Configuration must
// only be written while no command is in progress. The multiply and divide
// run through one shared 24-bit adder under a small sequencer.
module ring_queue_address_controller_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [rqac_pkg::OP_W-1:0]         req_opcode,
   input  wire logic                              req_access_failed,
   output logic                                   rsp_valid,
   output logic      [rqac_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [rqac_pkg::ADDR_W-1:0]       rsp_access_address,
   output logic                                   rsp_access_strobe,
   output logic      [rqac_pkg::COUNT_W-1:0]      rsp_item_count,
   output logic                                   rsp_is_empty,
   output logic                                   rsp_is_full,
   input  wire logic                              csr_we,
   input  wire logic [rqac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rqac_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned AW = rqac_pkg::ADDR_W;
   localparam int unsigned CW = rqac_pkg::COUNT_W;
   localparam int unsigned EW = rqac_pkg::ENTRY_W;

   // Configuration registers.
   logic [AW-1:0] base_ff;
   logic [CW-1:0] region_ff;
   logic [EW-1:0] entry_ff;

   // Queue state.
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] cap_ff;
   logic          setup_ok_ff;

   // Command held while the sequencer works on it.
   rqac_pkg::opcode_type op_ff;
   rqac_pkg::status_type status_ff, status_now;
   logic                 xfer_ff, xfer_now;

   // Multiply and divide working registers.
   logic [AW-1:0]   acc_ff, acc_in;
   logic [AW-1:0]   mcand_ff;
   logic [EW-1:0]   mplier_ff;
   logic [CW-1:0]   qd_ff, qd_in;
   logic [EW-1:0]   rem_ff, rem_in;
   logic [EW:0]     rem_sh;
   logic            div_ge;

   // Result registers.
   logic                 rsp_valid_ff;
   rqac_pkg::status_type rsp_status_ff;
   logic [AW-1:0]        rsp_addr_ff;
   logic                 rsp_strobe_ff;
   logic [CW-1:0]        rsp_count_ff;
   logic                 rsp_empty_ff;
   logic                 rsp_full_ff;

   logic                 cfg_write;
   logic                 check_ok;
   rqac_pkg::opcode_type req_op;
   rqac_pkg::ctrl_type   ctrl;

   logic [rqac_pkg::ALU_W-1:0] alu_a, alu_b;
   logic                       alu_sub;
   logic [rqac_pkg::ALU_W:0]   alu_sum;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                             input logic [CW-1:0] cap);
      logic [CW-1:0] nxt;
      nxt = {1'b0, idx} + CW'(1);
      return (nxt >= cap) ? '0 : nxt[AW-1:0];
   endfunction

   assign req_op    = rqac_pkg::opcode_type'(req_opcode);
   assign cfg_write = csr_we && ((csr_index == rqac_pkg::CSR_REGION_BASE)
                                 || (csr_index == rqac_pkg::CSR_REGION_BYTES)
                                 || (csr_index == rqac_pkg::CSR_ENTRY_BYTES));

   // Region check: nonzero item size, at least one item, region inside memory.
   assign check_ok = (entry_ff != '0)
      && (region_ff >= CW'(entry_ff))
      && ((33'(base_ff) + 33'(region_ff)) <= rqac_pkg::MEM_BYTES);

   // Decision at acceptance: which status the command gets and whether a
   // transfer is issued.
   always_comb begin
      status_now = rqac_pkg::ST_OK;
      xfer_now   = 1'b0;
      if (req_op == rqac_pkg::OP_CLEAR) begin
         status_now = rqac_pkg::ST_OK;
      end else if (!setup_ok_ff) begin
         status_now = rqac_pkg::ST_INVALID;
      end else if (req_op == rqac_pkg::OP_PUT) begin
         if (held_ff >= cap_ff) begin
            status_now = rqac_pkg::ST_FULL;
         end else begin
            xfer_now   = 1'b1;
            status_now = req_access_failed ? rqac_pkg::ST_FAULT : rqac_pkg::ST_OK;
         end
      end else begin
         if (held_ff == '0) begin
            status_now = rqac_pkg::ST_EMPTY;
         end else begin
            xfer_now   = 1'b1;
            status_now = req_access_failed ? rqac_pkg::ST_FAULT : rqac_pkg::ST_OK;
         end
      end
   end

   rqac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cfg_write (cfg_write),
      .xfer_now  (xfer_now),
      .check_ok  (check_ok),
      .busy      (busy),
      .ctrl      (ctrl)
   );

   // The shared adder compares the partial remainder with the item size while
   // dividing, and adds the shifted index into the address while multiplying.
   assign rem_sh = {rem_ff, qd_ff[CW-1]};

   always_comb begin
      if (ctrl.div_step) begin
         alu_a   = rqac_pkg::ALU_W'(rem_sh);
         alu_b   = rqac_pkg::ALU_W'(entry_ff);
         alu_sub = 1'b1;
      end else begin
         alu_a   = rqac_pkg::ALU_W'(acc_ff);
         alu_b   = rqac_pkg::ALU_W'(mcand_ff);
         alu_sub = 1'b0;
      end
   end

   rqac_alu u_alu (
      .op_a     (alu_a),
      .op_b     (alu_b),
      .subtract (alu_sub),
      .sum      (alu_sum)
   );

   always_comb begin
      div_ge = alu_sum[rqac_pkg::ALU_W];
      rem_in = div_ge ? alu_sum[EW-1:0] : rem_sh[EW-1:0];
      qd_in  = {qd_ff[CW-2:0], div_ge};
      acc_in = mplier_ff[0] ? alu_sum[AW-1:0] : acc_ff;
   end

   // Pointer and count update at the end of a command. A fault or a peek
   // leaves them as they are.
   always_comb begin
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      held_in   = held_ff;
      if (op_ff == rqac_pkg::OP_CLEAR) begin
         rd_idx_in = '0;
         wr_idx_in = '0;
         held_in   = '0;
      end else if (xfer_ff && (status_ff == rqac_pkg::ST_OK)) begin
         if (op_ff == rqac_pkg::OP_PUT) begin
            wr_idx_in = advance(wr_idx_ff, cap_ff);
            held_in   = held_ff + CW'(1);
         end else if (op_ff == rqac_pkg::OP_GET) begin
            rd_idx_in = advance(rd_idx_ff, cap_ff);
            held_in   = held_ff - CW'(1);
         end
      end
   end

   // Control state: configuration, pointers, capacity and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= rqac_pkg::RESET_BASE;
         region_ff    <= rqac_pkg::RESET_REGION;
         entry_ff     <= rqac_pkg::RESET_ENTRY;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         held_ff      <= '0;
         cap_ff       <= rqac_pkg::RESET_CAP;
         setup_ok_ff  <= rqac_pkg::RESET_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.finish;
         if (cfg_write) begin
            case (csr_index)
               rqac_pkg::CSR_REGION_BASE:  base_ff   <= csr_wdata[AW-1:0];
               rqac_pkg::CSR_REGION_BYTES: region_ff <= csr_wdata[CW-1:0];
               rqac_pkg::CSR_ENTRY_BYTES:  entry_ff  <= csr_wdata[EW-1:0];
               default: begin
               end
            endcase
            rd_idx_ff <= '0;
            wr_idx_ff <= '0;
            held_ff   <= '0;
         end else if (ctrl.finish) begin
            rd_idx_ff <= rd_idx_in;
            wr_idx_ff <= wr_idx_in;
            held_ff   <= held_in;
         end
         if (ctrl.check) begin
            setup_ok_ff <= check_ok;
            if (!check_ok) begin
               cap_ff <= '0;
            end
         end
         if (ctrl.div_last) begin
            cap_ff <= qd_in;
         end
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         op_ff     <= req_op;
         status_ff <= status_now;
         xfer_ff   <= xfer_now;
         acc_ff    <= base_ff;
         mcand_ff  <= (req_op == rqac_pkg::OP_PUT) ? wr_idx_ff : rd_idx_ff;
         mplier_ff <= entry_ff;
      end else if (ctrl.mul_step) begin
         acc_ff    <= acc_in;
         mcand_ff  <= {mcand_ff[AW-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[EW-1:1]};
      end
      if (ctrl.check) begin
         qd_ff  <= region_ff;
         rem_ff <= '0;
      end else if (ctrl.div_step) begin
         qd_ff  <= qd_in;
         rem_ff <= rem_in;
      end
      if (ctrl.finish) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= xfer_ff ? acc_ff : '0;
         rsp_strobe_ff <= xfer_ff;
         rsp_count_ff  <= held_in;
         rsp_empty_ff  <= (held_in == '0);
         rsp_full_ff   <= (held_in >= cap_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_access_address = rsp_addr_ff;
   assign rsp_access_strobe  = rsp_strobe_ff;
   assign rsp_item_count     = rsp_count_ff;
   assign rsp_is_empty       = rsp_empty_ff;
   assign rsp_is_full        = rsp_full_ff;

`ifndef NO_ASSERTIONS
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(ctrl.finish))
      else $error("result beat without a finished command");

   a_rsp_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result beat lasted more than one cycle");

   a_held_in_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap_ff)
      else $error("item count exceeds capacity");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (cap_ff != '0) |-> ((CW'(rd_idx_ff) < cap_ff) && (CW'(wr_idx_ff) < cap_ff)))
      else $error("queue index outside capacity");

   a_no_xfer_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_strobe_ff) |-> (rsp_addr_ff == '0))
      else $error("address given without a transfer");
`endif

endmodule

`default_nettype wire
